@@ hdl/mbd_pkg.sv @@
`timescale 1ns / 1ps

package mbd_pkg;

	localparam int WORD_W  = 32;
	localparam int DELAY_W = 32;
	localparam int STAMP_W = 32;
	localparam int INDEX_W = 5;

	typedef logic [1:0] func_t;
	typedef logic [1:0] kind_t;

	// request codes
	localparam func_t FUNC_SAMPLE = 2'd0;
	localparam func_t FUNC_CONFIG = 2'd1;
	localparam func_t FUNC_REINIT = 2'd2;

	// result codes
	localparam kind_t KIND_EDGE   = 2'd0;
	localparam kind_t KIND_DONE   = 2'd1;
	localparam kind_t KIND_REJECT = 2'd2;

	// register indexes
	localparam logic REG_INPUT_MASK = 1'b0;
	localparam logic REG_BYTE_WIDTH = 1'b1;

	// per-lane commands for one evaluation cycle
	typedef struct packed {
		logic reinit;
		logic config_hit;
		logic sample;
	} lane_ctl_t;

	// load command into the merge stage
	typedef struct packed {
		logic  sample;
		logic  single;
		kind_t kind;
	} mbd_load_t;

endpackage

@@ hdl/mbd_req_if.sv @@
`timescale 1ns / 1ps

interface mbd_req_if import mbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	func_t                 func;
	logic [WORD_W-1:0]     sample_word;
	logic [STAMP_W-1:0]    now_ms;
	logic [INDEX_W-1:0]    bit_index;
	logic [DELAY_W-1:0]    debounce_ms;
	logic                  polarity;

	modport source (
		output valid, func, sample_word, now_ms, bit_index, debounce_ms, polarity,
		input  ready
	);

	modport sink (
		input  valid, func, sample_word, now_ms, bit_index, debounce_ms, polarity,
		output ready
	);
endinterface

@@ hdl/mbd_rsp_if.sv @@
`timescale 1ns / 1ps

interface mbd_rsp_if import mbd_pkg::*; ();
	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [INDEX_W-1:0] event_bit;
	logic               rising;
	logic               now_active;
	logic [STAMP_W-1:0] stamp_ms;
	logic               last;

	modport source (
		output valid, kind, event_bit, rising, now_active, stamp_ms, last,
		input  ready
	);

	modport sink (
		input  valid, kind, event_bit, rising, now_active, stamp_ms, last,
		output ready
	);
endinterface

@@ hdl/mbd_lane.sv @@
`timescale 1ns / 1ps

module mbd_lane import mbd_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctl_t            ctl,
	input  logic                 level,
	input  logic                 polarity,
	input  logic [TIME_BITS-1:0] now,
	input  logic [DELAY_W-1:0]   delay,
	output logic                 fire,
	output logic                 inv_pol
);

	localparam int CMP_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

	logic                 enabled_q;
	logic                 inv_pol_q;
	logic                 debouncing_q;
	logic                 stable_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [TIME_BITS-1:0] start_q;

	logic                 changed;
	logic [TIME_BITS-1:0] elapsed;
	logic                 expired;

	// a fresh change starts its timer now, so elapsed is zero
	always_comb begin
		changed = level != stable_q;
		elapsed = debouncing_q ? (now - start_q) : '0;
		expired = CMP_W'(elapsed) >= CMP_W'(delay_q);
		fire    = ctl.sample && enabled_q && changed && expired;
	end

	assign inv_pol = inv_pol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			inv_pol_q    <= 1'b0;
			debouncing_q <= 1'b0;
			stable_q     <= 1'b0;
		end else if (ctl.reinit) begin
			enabled_q    <= 1'b0;
			inv_pol_q    <= 1'b0;
			debouncing_q <= 1'b0;
			stable_q     <= level;
		end else if (ctl.config_hit) begin
			enabled_q    <= 1'b1;
			inv_pol_q    <= polarity;
			debouncing_q <= 1'b0;
			stable_q     <= level;
		end else if (ctl.sample && enabled_q) begin
			if (changed) begin
				if (fire) begin
					stable_q     <= level;
					debouncing_q <= 1'b0;
				end else begin
					debouncing_q <= 1'b1;
				end
			end else begin
				// bounced back to the stable level
				debouncing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.config_hit) begin
			delay_q <= delay;
		end
		if (ctl.sample && enabled_q && changed && !debouncing_q) begin
			start_q <= now;
		end
	end

endmodule

@@ hdl/mbd_merge.sv @@
`timescale 1ns / 1ps

module mbd_merge import mbd_pkg::*; #(
	parameter int LANES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbd_load_t          ld,
	input  logic [LANES-1:0]   fire,
	input  logic [LANES-1:0]   level,
	input  logic [LANES-1:0]   inv_pol,
	input  logic [STAMP_W-1:0] stamp,
	output logic               busy,
	mbd_rsp_if.source          rsp
);

	logic [LANES-1:0]   pending_q;
	logic               single_q;
	kind_t              kind_q;

	logic               valid_q;
	kind_t              out_kind_q;
	logic [INDEX_W-1:0] out_bit_q;
	logic               out_rising_q;
	logic               out_active_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic               out_last_q;

	logic               can_load;
	logic [LANES-1:0]   pick;
	logic [LANES-1:0]   rest;
	logic [INDEX_W-1:0] pick_idx;

	// lowest pending lane first
	always_comb begin
		can_load = !valid_q || rsp.ready;
		pick     = pending_q & (~pending_q + LANES'(1));
		rest     = pending_q & ~pick;
		pick_idx = '0;
		for (int i = 0; i < LANES; i++) begin
			if (pick[i]) begin
				pick_idx = pick_idx | INDEX_W'(i);
			end
		end
	end

	assign busy = single_q || (pending_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			single_q  <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (ld.sample) begin
				pending_q <= fire;
			end else if (can_load && !single_q) begin
				pending_q <= rest;
			end
			if (ld.single) begin
				single_q <= 1'b1;
			end else if (can_load) begin
				single_q <= 1'b0;
			end
			if (can_load) begin
				valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.single) begin
			kind_q <= ld.kind;
		end
		if (can_load) begin
			out_stamp_q <= stamp;
			if (single_q) begin
				out_kind_q   <= kind_q;
				out_bit_q    <= '0;
				out_rising_q <= 1'b0;
				out_active_q <= 1'b0;
				out_last_q   <= 1'b1;
			end else begin
				out_kind_q   <= KIND_EDGE;
				out_bit_q    <= pick_idx;
				out_rising_q <= |(pick & level);
				out_active_q <= |(pick & (level ^ inv_pol));
				out_last_q   <= rest == '0;
			end
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.event_bit  = out_bit_q;
	assign rsp.rising     = out_rising_q;
	assign rsp.now_active = out_active_q;
	assign rsp.stamp_ms   = out_stamp_q;
	assign rsp.last       = out_last_q;

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.sample || ld.single) |-> !busy)
		else $error("merge loaded while still draining");

	a_pending_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		!ld.sample |=> (pending_q & ~$past(pending_q)) == '0)
		else $error("pending events grew without a load");

endmodule

@@ hdl/multi_bit_debounce_edge_events.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake         | beat contents
// req       | in  | valid/ready       | func, sample_word, now_ms, bit_index, debounce_ms, polarity
// rsp       | out | valid/ready       | kind, event_bit, rising, now_active, stamp_ms, last
// apb       | in  | psel/penable      | input_mask at 0x0, byte_width at 0x4
//
// a request is taken only when the block is idle; it passes through the item
// register and the lanes, then the merge stage sends one result beat per cycle
// while rsp is ready, lowest bit first
// a sample without events sends no result beat and frees the block
// rsp stalls hold the output register; req.ready stays low until the last beat
// is in the output register, so a stalled final beat can overlap the next request
// reset clears lane flags and stable levels; delays and timer starts load on use

module multi_bit_debounce_edge_events import mbd_pkg::*; #(
	parameter int NUM_INPUTS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mbd_req_if.sink     req,
	mbd_rsp_if.source   rsp
);

	// the bit index can only reach the low 32 inputs
	localparam int LANES = (NUM_INPUTS < WORD_W) ? NUM_INPUTS : WORD_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]           state_q;

	// configuration registers
	logic [WORD_W-1:0]    input_mask_q;
	logic [2:0]           byte_width_q;
	logic                 cfg_write;

	// item register
	func_t                func_q;
	logic [WORD_W-1:0]    word_q;
	logic [TIME_BITS-1:0] now_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [DELAY_W-1:0]   delay_q;
	logic                 pol_q;

	logic                 accept;
	logic                 eval;
	logic [WORD_W-1:0]    used_word;
	logic                 cfg_ok;
	mbd_load_t            ld;
	logic [LANES-1:0]     fire;
	logic [LANES-1:0]     inv_pol;
	logic                 merge_busy;

	// apb: writes on the access phase, no wait states
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_INPUT_MASK: prdata = input_mask_q;
			REG_BYTE_WIDTH: prdata = 32'(byte_width_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mask_q <= '1;
			byte_width_q <= 3'd4;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_INPUT_MASK: input_mask_q <= pwdata;
				REG_BYTE_WIDTH: byte_width_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// bytes above byte_width read as zero; widths past four use the whole word
	always_comb begin
		case (byte_width_q)
			3'd0:    used_word = '0;
			3'd1:    used_word = req.sample_word & 32'h0000_00ff;
			3'd2:    used_word = req.sample_word & 32'h0000_ffff;
			3'd3:    used_word = req.sample_word & 32'h00ff_ffff;
			default: used_word = req.sample_word;
		endcase
	end

	// control
	assign req.ready = state_q == ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign eval      = state_q == ST_EVAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_EVAL;
				ST_EVAL:  state_q <= ST_DRAIN;
				ST_DRAIN: if (!merge_busy) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			word_q  <= used_word;
			now_q   <= TIME_BITS'(req.now_ms);
			stamp_q <= req.now_ms;
			idx_q   <= req.bit_index;
			delay_q <= req.debounce_ms;
			pol_q   <= req.polarity;
		end
	end

	// configure is refused for bits outside the mask or beyond the lanes
	assign cfg_ok = ({1'b0, idx_q} < (INDEX_W + 1)'(LANES)) && input_mask_q[idx_q];

	always_comb begin
		ld.sample = eval && (func_q == FUNC_SAMPLE);
		ld.single = eval && ((func_q == FUNC_CONFIG) || (func_q == FUNC_REINIT));
		ld.kind   = ((func_q == FUNC_CONFIG) && !cfg_ok) ? KIND_REJECT : KIND_DONE;
	end

	// one debounce lane per input bit
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lane_ctl_t ctl;

		always_comb begin
			ctl.reinit     = eval && (func_q == FUNC_REINIT);
			ctl.config_hit = eval && (func_q == FUNC_CONFIG) && cfg_ok
				&& (idx_q == INDEX_W'(g));
			ctl.sample     = eval && (func_q == FUNC_SAMPLE) && input_mask_q[g];
		end

		mbd_lane #(
			.TIME_BITS(TIME_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.level      (word_q[g]),
			.polarity   (pol_q),
			.now        (now_q),
			.delay      (delay_q),
			.fire       (fire[g]),
			.inv_pol    (inv_pol[g])
		);
	end

	// serialize lane results onto the output
	mbd_merge #(
		.LANES(LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.fire       (fire),
		.level      (word_q[LANES-1:0]),
		.inv_pol    (inv_pol),
		.stamp      (stamp_q),
		.busy       (merge_busy),
		.rsp        (rsp)
	);

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EVAL)
		else $error("accepted request did not reach the lanes");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !merge_busy)
		else $error("idle with results still pending");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind != KIND_EDGE)) |-> rsp.last)
		else $error("done or reject beat without last");

	a_edge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind == KIND_EDGE)) |-> ({1'b0, rsp.event_bit} < (INDEX_W + 1)'(LANES)))
		else $error("edge beat names a missing lane");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// self-checking bench for the multi-channel input debouncer
module testbench;
	import mbd_pkg::*;

	// the one code the package leaves unnamed; the block must ignore it
	localparam func_t FUNC_UNUSED    = 2'd3;
	localparam int    WATCHDOG_LIMIT = 1000;
	localparam int    QUIET_CYCLES   = 10;
	localparam int    MAX_REPORTS    = 10;

	// one request beat as the bench sees it
	typedef struct {
		func_t              func;
		logic [WORD_W-1:0]  sample_word;
		logic [STAMP_W-1:0] now_ms;
		logic [INDEX_W-1:0] bit_index;
		logic [DELAY_W-1:0] debounce_ms;
		logic               polarity;
	} debounce_req_t;

	// one result beat
	typedef struct {
		kind_t              kind;
		logic [INDEX_W-1:0] event_bit;
		logic               rising;
		logic               now_active;
		logic [STAMP_W-1:0] stamp_ms;
		logic               last;
	} debounce_beat_t;

	// shadow of the debouncer: per-bit setup and timers, plus the beats still owed
	class debounce_scoreboard;
		bit [31:0]          mask;
		bit [2:0]           width;
		bit                 enabled[32];
		bit                 inv_pol[32];
		bit [DELAY_W-1:0]   delay_ms[32];
		bit                 settling[32];
		bit                 stable[32];
		bit [STAMP_W-1:0]   start_ms[32];
		debounce_beat_t     owed_beats[$];
		int                 errors;
		int                 reported;
		int                 n_sample;
		int                 n_config;
		int                 n_reinit;
		int                 n_unused;
		int                 n_edges;
		int                 n_rejects;
		int                 n_beats;

		function new();
			mask  = '1;
			width = 3'd4;
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == REG_INPUT_MASK)
				mask = value;
			else
				width = value[2:0];
		endfunction

		function void note_failure(string msg);
			errors++;
			if (reported < MAX_REPORTS) begin
				reported++;
				$display("%t: %s", $realtime, msg);
			end
		endfunction

		function void check_register(logic idx, logic [31:0] got);
			logic [31:0] want;
			want = (idx == REG_INPUT_MASK) ? mask : {29'd0, width};
			if (got !== want)
				note_failure($sformatf("register %0d readback: expected %h got %h",
					idx, want, got));
		endfunction

		function void add_beat(kind_t kind, int idx, bit rise, bit act,
				bit [STAMP_W-1:0] stamp, bit fin);
			debounce_beat_t b;
			b.kind       = kind;
			b.event_bit  = idx[INDEX_W-1:0];
			b.rising     = rise;
			b.now_active = act;
			b.stamp_ms   = stamp;
			b.last       = fin;
			owed_beats.push_back(b);
		endfunction

		// bytes above the configured width read as zero; widths past four mean four
		function bit [WORD_W-1:0] visible_word(bit [WORD_W-1:0] raw);
			case (width)
				3'd0: return '0;
				3'd1: return raw & 32'h0000_00ff;
				3'd2: return raw & 32'h0000_ffff;
				3'd3: return raw & 32'h00ff_ffff;
				default: return raw;
			endcase
		endfunction

		function void note_request(debounce_req_t r);
			bit [WORD_W-1:0]  word;
			bit [STAMP_W-1:0] elapsed;
			bit               cur;
			int               first;
			word  = visible_word(r.sample_word);
			first = owed_beats.size();
			case (r.func)
				FUNC_REINIT: begin
					n_reinit++;
					for (int i = 0; i < 32; i++) begin
						enabled[i]  = 1'b0;
						inv_pol[i]  = 1'b0;
						settling[i] = 1'b0;
						stable[i]   = word[i];
					end
					add_beat(KIND_DONE, 0, 1'b0, 1'b0, r.now_ms, 1'b1);
				end
				FUNC_CONFIG: begin
					n_config++;
					if (!mask[r.bit_index]) begin
						n_rejects++;
						add_beat(KIND_REJECT, 0, 1'b0, 1'b0, r.now_ms, 1'b1);
					end else begin
						enabled[r.bit_index]  = 1'b1;
						inv_pol[r.bit_index]  = r.polarity;
						delay_ms[r.bit_index] = r.debounce_ms;
						settling[r.bit_index] = 1'b0;
						stable[r.bit_index]   = word[r.bit_index];
						add_beat(KIND_DONE, 0, 1'b0, 1'b0, r.now_ms, 1'b1);
					end
				end
				FUNC_SAMPLE: begin
					n_sample++;
					for (int i = 0; i < 32; i++) begin
						if (!mask[i] || !enabled[i])
							continue;
						cur = word[i];
						if (!settling[i]) begin
							if (cur == stable[i])
								continue;
							start_ms[i] = r.now_ms;
							settling[i] = 1'b1;
						end else if (cur == stable[i]) begin
							// bounced back before the time ran out
							settling[i] = 1'b0;
							continue;
						end
						elapsed = r.now_ms - start_ms[i];
						if (elapsed >= delay_ms[i]) begin
							n_edges++;
							add_beat(KIND_EDGE, i, cur, cur != inv_pol[i], r.now_ms, 1'b0);
							stable[i]   = cur;
							settling[i] = 1'b0;
						end
					end
					if (owed_beats.size() > first)
						owed_beats[owed_beats.size()-1].last = 1'b1;
				end
				default: n_unused++;
			endcase
		endfunction

		function void check_result(debounce_beat_t got);
			debounce_beat_t want;
			n_beats++;
			if (owed_beats.size() == 0) begin
				note_failure($sformatf("unexpected beat: kind=%0d bit=%0d stamp=%h last=%0d",
					got.kind, got.event_bit, got.stamp_ms, got.last));
				return;
			end
			want = owed_beats.pop_front();
			if (got.kind !== want.kind || got.event_bit !== want.event_bit ||
					got.rising !== want.rising || got.now_active !== want.now_active ||
					got.stamp_ms !== want.stamp_ms || got.last !== want.last)
				note_failure($sformatf({"beat mismatch: expected kind=%0d bit=%0d rise=%0d ",
					"act=%0d stamp=%h last=%0d, got kind=%0d bit=%0d rise=%0d act=%0d ",
					"stamp=%h last=%0d"},
					want.kind, want.event_bit, want.rising, want.now_active, want.stamp_ms,
					want.last, got.kind, got.event_bit, got.rising, got.now_active,
					got.stamp_ms, got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mbd_req_if req_ch ();
	mbd_rsp_if rsp_ch ();

	debounce_scoreboard sb = new();

	// stimulus state: the levels on the pins and the millisecond clock
	bit [WORD_W-1:0]  levels;
	bit [WORD_W-1:0]  last_flip;
	bit [STAMP_W-1:0] wall_ms;

	// idling knobs, changed per phase
	int burst_left;
	bit sender_idle;
	int stall_mode;
	int stall_left;
	int idle_cycles;

	debounce_req_t  seen_req;
	debounce_beat_t seen_beat;

	multi_bit_debounce_edge_events DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result sink ready: always on, short frequent stalls, or rare long ones
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_ch.ready = 1'b0;
			stall_left--;
		end else begin
			case (stall_mode)
				1: if ($urandom_range(0, 3) == 0) begin
					rsp_ch.ready = 1'b0;
					stall_left = $urandom_range(0, 2);
				end else begin
					rsp_ch.ready = 1'b1;
				end
				2: if ($urandom_range(0, 15) == 0) begin
					rsp_ch.ready = 1'b0;
					stall_left = $urandom_range(4, 12);
				end else begin
					rsp_ch.ready = 1'b1;
				end
				default: rsp_ch.ready = 1'b1;
			endcase
		end
	end

	// monitor: results are checked before the new request is predicted, so the
	// owed queue is always in beat order; the watchdog counts quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_beat.kind       = rsp_ch.kind;
				seen_beat.event_bit  = rsp_ch.event_bit;
				seen_beat.rising     = rsp_ch.rising;
				seen_beat.now_active = rsp_ch.now_active;
				seen_beat.stamp_ms   = rsp_ch.stamp_ms;
				seen_beat.last       = rsp_ch.last;
				sb.check_result(seen_beat);
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_req.func        = req_ch.func;
				seen_req.sample_word = req_ch.sample_word;
				seen_req.now_ms      = req_ch.now_ms;
				seen_req.bit_index   = req_ch.bit_index;
				seen_req.debounce_ms = req_ch.debounce_ms;
				seen_req.polarity    = req_ch.polarity;
				sb.note_request(seen_req);
			end
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles, %0d still owed",
					idle_cycles, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// one request beat; bursts of random length, with random gaps in between when sender_idle is set
	task automatic send_req(func_t f, bit [WORD_W-1:0] word, bit [STAMP_W-1:0] now,
			bit [INDEX_W-1:0] idx, bit [DELAY_W-1:0] delay, bit pol);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = sender_idle ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.func        = f;
		req_ch.sample_word = word;
		req_ch.now_ms      = now;
		req_ch.bit_index   = idx;
		req_ch.debounce_ms = delay;
		req_ch.polarity    = pol;
		req_ch.valid       = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// apb write then readback of the same register
	task automatic reg_write(logic idx, logic [31:0] value);
		logic [31:0] got;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		sb.check_register(idx, got);
	endtask

	// drain everything owed, then give a silent sample time to clear the pipe
	task automatic settle();
		req_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// mostly short delays, some zero, some huge so only a wrap can finish them
	task automatic configure_random_bit();
		int               roll;
		bit [DELAY_W-1:0] delay;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			delay = '0;
		else if (roll < 25)
			delay = $urandom();
		else if (roll < 30)
			delay = '1;
		else
			delay = $urandom_range(0, 10);
		send_req(FUNC_CONFIG, levels, wall_ms, INDEX_W'($urandom_range(0, 31)), delay,
			1'($urandom_range(0, 1)));
	endtask

	task automatic random_item();
		int pick;
		int roll;
		// time mostly creeps forward, now and then jumps or sits near the wrap
		roll = $urandom_range(0, 99);
		if (roll < 3)
			wall_ms = $urandom();
		else if (roll < 6)
			wall_ms = 32'hffff_ffff - $urandom_range(0, 6);
		else
			wall_ms += $urandom_range(0, 5);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_req(FUNC_REINIT, levels, wall_ms, INDEX_W'($urandom()), $urandom(),
				1'($urandom()));
		end else if (pick < 16) begin
			configure_random_bit();
		end else if (pick < 19) begin
			send_req(FUNC_UNUSED, $urandom(), $urandom(), INDEX_W'($urandom()), $urandom(),
				1'($urandom()));
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				levels = $urandom();
			end else if (roll < 23) begin
				// undo the last change: bounce
				levels ^= last_flip;
			end else if (roll < 70) begin
				last_flip = 32'd1 << $urandom_range(0, 7);
				if ($urandom_range(0, 1))
					last_flip |= 32'd1 << $urandom_range(0, 31);
				levels ^= last_flip;
			end
			send_req(FUNC_SAMPLE, levels, wall_ms, INDEX_W'($urandom()), $urandom(),
				1'($urandom()));
		end
	endtask

	task automatic run_phase(int n_items, bit [31:0] mask, bit [2:0] width, int stall,
			bit idle);
		settle();
		reg_write(REG_INPUT_MASK, mask);
		reg_write(REG_BYTE_WIDTH, {29'd0, width});
		stall_mode  = stall;
		sender_idle = idle;
		// start from a clean setup with a handful of bits armed
		send_req(FUNC_REINIT, levels, wall_ms, '0, '0, 1'b0);
		repeat (10) configure_random_bit();
		repeat (n_items) random_item();
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_ch.valid       = 1'b0;
		req_ch.func        = FUNC_SAMPLE;
		req_ch.sample_word = '0;
		req_ch.now_ms      = '0;
		req_ch.bit_index   = '0;
		req_ch.debounce_ms = '0;
		req_ch.polarity    = 1'b0;
		rsp_ch.ready       = 1'b0;
		stall_mode         = 1;
		sender_idle        = 1'b1;
		stall_left         = 0;
		burst_left         = 0;
		idle_cycles        = 0;
		levels             = '0;
		last_flip          = '0;
		wall_ms            = 32'd1000;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: full mask, full width
		reg_write(REG_INPUT_MASK, 32'hffff_ffff);
		reg_write(REG_BYTE_WIDTH, 32'd4);
		// nothing armed yet, so no result
		send_req(FUNC_SAMPLE, 32'hffff_ffff, 32'd100, '0, '0, 1'b0);
		send_req(FUNC_REINIT, 32'ha5a5_5a5a, 32'd101, '0, '0, 1'b0);
		// bit 0 zero delay active high, bit 31 zero delay active low
		send_req(FUNC_CONFIG, 32'ha5a5_5a5a, 32'd102, 5'd0, 32'd0, 1'b0);
		send_req(FUNC_CONFIG, 32'ha5a5_5a5a, 32'd103, 5'd31, 32'd0, 1'b1);
		send_req(FUNC_CONFIG, 32'ha5a5_5a5a, 32'd104, 5'd5, 32'd3, 1'b0);
		// longest possible delay, only reached by a full wrap of the clock
		send_req(FUNC_CONFIG, 32'ha5a5_5a5a, 32'd105, 5'd16, 32'hffff_ffff, 1'b1);
		// bits 0 and 31 fire at once, bits 5 and 16 start timing
		send_req(FUNC_SAMPLE, 32'h25a4_5a7b, 32'd200, '0, '0, 1'b0);
		// bit 5 goes back: debounce dropped silently
		send_req(FUNC_SAMPLE, 32'h25a4_5a5b, 32'd201, '0, '0, 1'b0);
		send_req(FUNC_SAMPLE, 32'h25a4_5a7b, 32'd202, '0, '0, 1'b0);
		send_req(FUNC_SAMPLE, 32'h25a4_5a7b, 32'd204, '0, '0, 1'b0);
		send_req(FUNC_SAMPLE, 32'h25a4_5a7b, 32'd205, '0, '0, 1'b0);
		// elapsed wraps to all ones: bit 16 finally fires
		send_req(FUNC_SAMPLE, 32'h25a4_5a7b, 32'd199, '0, '0, 1'b0);
		send_req(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 32'hffff_ffff, 1'b1);
		// falling on active high, rising on active low, timers across the wrap
		send_req(FUNC_SAMPLE, 32'ha5a5_5a5a, 32'hffff_fff0, '0, '0, 1'b0);
		send_req(FUNC_SAMPLE, 32'ha5a5_5a5a, 32'h0000_0002, '0, '0, 1'b0);
		send_req(FUNC_CONFIG, 32'ha5a5_5a5a, 32'h0000_0003, 5'd16, 32'd2, 1'b0);
		send_req(FUNC_REINIT, 32'h0000_0000, 32'h0000_0004, '0, '0, 1'b0);

		// random phases over a spread of register settings and idling styles
		run_phase(50, 32'hffff_ffff, 3'd4, 1, 1'b1);
		run_phase(35, $urandom(), 3'd1, 2, 1'b1);
		run_phase(10, 32'h0000_0000, 3'd4, 0, 1'b0);
		run_phase(20, 32'h8000_0001, 3'd2, 1, 1'b0);
		run_phase(35, $urandom(), 3'd3, 0, 1'b1);
		run_phase(10, 32'hffff_ffff, 3'd0, 1, 1'b1);
		run_phase(20, 32'hffff_ffff, 3'd7, 2, 1'b0);
		run_phase(65, 32'hffff_ffff, 3'd4, 1, 1'b1);

		settle();
		repeat (30) @(negedge clk);

		$display("covered %0d samples, %0d configures (%0d rejected), %0d reinits, %0d unused codes",
			sb.n_sample, sb.n_config, sb.n_rejects, sb.n_reinit, sb.n_unused);
		$display("checked %0d result beats with %0d edge events over 9 register settings, %0d errors",
			sb.n_beats, sb.n_edges, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
